// File: sv/pvn_pkg.sv
// Shared types and constants of the periodic value noise fBm block.
// Depends on nothing; every other file of the block but pvn_div_cell imports it.
package pvn_pkg;

   // Field widths fixed by the block's interface.
   localparam int COORD_W    = 28;
   localparam int NOISE_W    = 24;
   localparam int PERIOD_W   = 13;
   localparam int SEED_W     = 32;
   localparam int OCT_W      = 4;
   localparam int HASH_W     = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Multipliers of the 32-bit lattice hash.
   localparam logic [HASH_W-1:0] HASH_MUL_X    = 32'd374761393;
   localparam logic [HASH_W-1:0] HASH_MUL_Y    = 32'd668265263;
   localparam logic [HASH_W-1:0] HASH_MUL_SEED = 32'd2246822519;
   localparam logic [HASH_W-1:0] HASH_MUL_MIX  = 32'd1274126177;

   // Seed offset added for every further octave.
   localparam int SEED_STEP = 101;

   // Register reset values.
   localparam logic [PERIOD_W-1:0] BASE_PERIOD_RESET  = 13'd3;
   localparam logic [SEED_W-1:0]   NOISE_SEED_RESET   = 32'd0;
   localparam logic [OCT_W-1:0]    OCTAVE_COUNT_RESET = 4'd3;

   // Register index, taken from paddr[3:2].
   typedef enum logic [1:0] {
      CSR_BASE_PERIOD  = 2'd0,
      CSR_NOISE_SEED   = 2'd1,
      CSR_OCTAVE_COUNT = 2'd2
   } csr_index_type;

endpackage

// File: sv/pvn_if.sv
// Valid/ready channel interfaces for the coordinate requests and noise responses.
// Depends on pvn_pkg for the payload widths.
interface pvn_req_if;
   import pvn_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;

   modport source (output valid, output coord_x, output coord_y, input ready);
   modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

interface pvn_rsp_if;
   import pvn_pkg::*;
   logic               valid;
   logic               ready;
   logic [NOISE_W-1:0] noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface

// File: sv/pvn_div_cell.sv
// One restoring division cell: consumes one dividend bit, yields one quotient bit.
// Standalone; the top level chains these for the x wrap and the normalization.
module pvn_div_cell #(
   parameter int DVW = 13,
   parameter int DW  = 12,
   parameter int SBW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic [DVW-1:0] divisor,
   input  logic           in_valid,
   input  logic [DVW-1:0] in_rem,
   input  logic [DW-1:0]  in_dividend,
   input  logic [DW-1:0]  in_quot,
   input  logic [SBW-1:0] in_side,
   output logic           out_valid,
   output logic [DVW-1:0] out_rem,
   output logic [DW-1:0]  out_dividend,
   output logic [DW-1:0]  out_quot,
   output logic [SBW-1:0] out_side
);
   logic           valid_ff;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [DW-1:0]  dividend_ff, quot_ff;
   logic [SBW-1:0] side_ff;
   logic [DVW:0]   trial;
   logic           fits;

   // Shift in the next dividend bit and subtract when the divisor fits.
   always_comb begin
      trial  = {in_rem, in_dividend[DW-1]};
      fits   = trial >= {1'b0, divisor};
      rem_in = fits ? DVW'(trial - {1'b0, divisor}) : DVW'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff      <= rem_in;
         dividend_ff <= {in_dividend[DW-2:0], 1'b0};
         quot_ff     <= {in_quot[DW-2:0], fits};
         side_ff     <= in_side;
      end
   end

   assign out_valid    = valid_ff;
   assign out_rem      = rem_ff;
   assign out_dividend = dividend_ff;
   assign out_quot     = quot_ff;
   assign out_side     = side_ff;
endmodule

// File: sv/pvn_octave.sv
// Six-stage pipeline for one octave: lattice corners, hash, smoothstep and blend.
// Depends on pvn_pkg for widths and hash constants.
module pvn_octave #(
   parameter int OCT       = 0,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               enable,
   input  logic signed [pvn_pkg::COORD_W-1:0] coord_x,
   input  logic signed [pvn_pkg::COORD_W-1:0] coord_y,
   input  logic [pvn_pkg::PERIOD_W-1:0]       cell_mod,
   input  logic [pvn_pkg::PERIOD_W-1:0]       base_period,
   input  logic [pvn_pkg::SEED_W-1:0]         noise_seed,
   output logic [pvn_pkg::NOISE_W-1:0]        octave_value
);
   import pvn_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int SW = COORD_W + OCT;
   localparam int LW = SW - F;
   localparam logic [HASH_W-1:0] LOW_MASK  = (32'd1 << OCT) - 32'd1;
   localparam logic [SEED_W-1:0] SEED_OFS  = 32'(SEED_STEP * OCT);
   localparam logic [F+1:0]      THREE_ONE = (F+2)'(3) << F;
   localparam logic [F:0]        ONE       = (F+1)'(1) << F;

   // Linear interpolation step on Q0.24 values with a Q1.F weight.
   function automatic logic [NOISE_W-1:0] blend(input logic [NOISE_W-1:0] a,
                                                input logic [NOISE_W-1:0] b,
                                                input logic [F:0] s);
      logic [NOISE_W+F+1:0] acc;
      acc = (NOISE_W+F+2)'(a) * (NOISE_W+F+2)'(ONE - s)
          + (NOISE_W+F+2)'(b) * (NOISE_W+F+2)'(s);
      return acc[NOISE_W+F-1:F];
   endfunction

   logic signed [SW-1:0] xs, ys;
   logic signed [LW-1:0] x0, y0;
   logic [HASH_W-1:0]    period_k, xa_raw, xa_next, xa_in, xb_in;

   logic [HASH_W-1:0] xa_ff, xb_ff, ya_ff, yb_ff;
   logic [F-1:0]      fx_ff, fy_ff;
   logic [HASH_W-1:0] pxa_ff, pxb_ff, pya_ff, pyb_ff, ps_ff;
   logic [F-1:0]      ttx_ff, tty_ff, fx2_ff, fy2_ff;
   logic [2*F-1:0]    sqx, sqy;
   logic [HASH_W-1:0] h_in [4];
   logic [HASH_W-1:0] g_ff [4];
   logic [HASH_W-1:0] mix_ff [4];
   logic [NOISE_W-1:0] hv [4];
   logic [2*F+1:0]    prodx, prody;
   logic [F:0]        sx_ff, sy_ff, sx4_ff, sy4_ff, sy5_ff;
   logic [NOISE_W-1:0] ab_ff, cd_ff, value_ff;

   // Scale by 2^k, split into lattice cell and fraction, and wrap x.
   always_comb begin
      xs       = SW'(coord_x) <<< OCT;
      ys       = SW'(coord_y) <<< OCT;
      x0       = xs[SW-1:F];
      y0       = ys[SW-1:F];
      period_k = 32'(base_period) << OCT;
      xa_raw   = (32'(cell_mod) << OCT) | (32'(x0) & LOW_MASK);
      xa_next  = xa_raw + 32'd1;
      if (base_period == '0) begin
         xa_in = '0;
         xb_in = '0;
      end else begin
         xa_in = xa_raw;
         xb_in = (xa_next == period_k) ? '0 : xa_next;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         xa_ff <= xa_in;
         xb_ff <= xb_in;
         ya_ff <= 32'(y0);
         yb_ff <= 32'(y0) + 32'd1;
         fx_ff <= xs[F-1:0];
         fy_ff <= ys[F-1:0];
      end
   end

   // Hash products and the squared fractions.
   assign sqx = (2*F)'(fx_ff) * (2*F)'(fx_ff);
   assign sqy = (2*F)'(fy_ff) * (2*F)'(fy_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         pxa_ff <= xa_ff * HASH_MUL_X;
         pxb_ff <= xb_ff * HASH_MUL_X;
         pya_ff <= ya_ff * HASH_MUL_Y;
         pyb_ff <= yb_ff * HASH_MUL_Y;
         ps_ff  <= (noise_seed + SEED_OFS) * HASH_MUL_SEED;
         ttx_ff <= sqx[2*F-1:F];
         tty_ff <= sqy[2*F-1:F];
         fx2_ff <= fx_ff;
         fy2_ff <= fy_ff;
      end
   end

   // Corner sums, first hash fold, and the smoothstep weights.
   always_comb begin
      h_in[0] = pxa_ff + pya_ff + ps_ff;
      h_in[1] = pxb_ff + pya_ff + ps_ff;
      h_in[2] = pxa_ff + pyb_ff + ps_ff;
      h_in[3] = pxb_ff + pyb_ff + ps_ff;
      prodx   = (2*F+2)'(ttx_ff) * (2*F+2)'(THREE_ONE - {1'b0, fx2_ff, 1'b0});
      prody   = (2*F+2)'(tty_ff) * (2*F+2)'(THREE_ONE - {1'b0, fy2_ff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int c = 0; c < 4; c++) begin
            g_ff[c] <= h_in[c] ^ (h_in[c] >> 13);
         end
         sx_ff <= prodx[2*F:F];
         sy_ff <= prody[2*F:F];
      end
   end

   // Second hash multiply.
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int c = 0; c < 4; c++) begin
            mix_ff[c] <= g_ff[c] * HASH_MUL_MIX;
         end
         sx4_ff <= sx_ff;
         sy4_ff <= sy_ff;
      end
   end

   // Final hash fold gives the corner values; blend along x.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         hv[c] = NOISE_W'(mix_ff[c] ^ (mix_ff[c] >> 16));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ab_ff  <= blend(hv[0], hv[1], sx4_ff);
         cd_ff  <= blend(hv[2], hv[3], sx4_ff);
         sy5_ff <= sy4_ff;
      end
   end

   // Blend along y.
   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= blend(ab_ff, cd_ff, sy5_ff);
      end
   end

   assign octave_value = value_ff;
endmodule

// File: sv/periodic_value_noise_fbm.sv
// Periodic value noise fBm top level: register port, cell chains, octave units, output queue.
// Depends on pvn_pkg, pvn_if, pvn_div_cell and pvn_octave.
//
// Takes one coordinate pair per clock while the output queue has a free entry and returns
// one normalized noise sample per pair, in order. The transfer edge of a request loads the
// first of these register stages: one remainder cell per integer bit of coord_x reduces it
// modulo base_period, a sign-fix register fixes the sign, the octave pipelines compute all
// octaves side by side, a sum register sums them, 24 quotient cells divide by the amplitude
// sum, and the output queue takes the result. A two-entry output queue lets the block keep
// accepting while a response waits; the chain halts only when both entries are full. The
// user must write the registers only while no request is in flight; the block itself does
// not enforce it.
module periodic_value_noise_fbm #(
   parameter int MAX_OCTAVES = 8,
   parameter int FRAC_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   pvn_req_if.sink                        req_chan,
   pvn_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pvn_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pvn_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pvn_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import pvn_pkg::*;

   localparam int M       = MAX_OCTAVES;
   localparam int IW      = COORD_W - FRAC_BITS;
   localparam int MSIDE_W = 2 * COORD_W + 1;
   localparam int SUM_W   = NOISE_W + M;
   localparam int OCT_LAT = 6;

   // Configuration registers.
   logic [PERIOD_W-1:0] base_period_ff;
   logic [SEED_W-1:0]   noise_seed_ff;
   logic [OCT_W-1:0]    octave_count_ff;
   logic [OCT_W-1:0]    octaves_used;
   logic                csr_write;
   csr_index_type       csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_period_ff  <= BASE_PERIOD_RESET;
         noise_seed_ff   <= NOISE_SEED_RESET;
         octave_count_ff <= OCTAVE_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_PERIOD:  base_period_ff  <= pwdata[PERIOD_W-1:0];
            CSR_NOISE_SEED:   noise_seed_ff   <= pwdata[SEED_W-1:0];
            CSR_OCTAVE_COUNT: octave_count_ff <= pwdata[OCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_BASE_PERIOD:  prdata = CSR_DATA_W'(base_period_ff);
         CSR_NOISE_SEED:   prdata = CSR_DATA_W'(noise_seed_ff);
         CSR_OCTAVE_COUNT: prdata = CSR_DATA_W'(octave_count_ff);
         default:          prdata = '0;
      endcase
   end

   assign octaves_used = (octave_count_ff > OCT_W'(M)) ? OCT_W'(M) : octave_count_ff;

   // The whole chain moves while the output queue has a free entry.
   logic [1:0] fifo_count_ff, fifo_count_in;
   logic       advance;

   assign advance        = fifo_count_ff != 2'd2;
   assign req_chan.ready = advance;

   // Remainder chain: |integer part of x| modulo max(1, base_period).
   logic [IW-1:0]       int_x, int_mag;
   logic                neg_x;
   logic [PERIOD_W-1:0] wrap_div;

   logic                mod_valid [IW+1];
   logic [PERIOD_W-1:0] mod_rem   [IW+1];
   logic [IW-1:0]       mod_dvd   [IW+1];
   logic [IW-1:0]       mod_quot  [IW+1];
   logic [MSIDE_W-1:0]  mod_side  [IW+1];

   always_comb begin
      int_x    = req_chan.coord_x[COORD_W-1:FRAC_BITS];
      neg_x    = req_chan.coord_x[COORD_W-1];
      int_mag  = neg_x ? (~int_x + 1'b1) : int_x;
      wrap_div = (base_period_ff == '0) ? PERIOD_W'(1) : base_period_ff;
   end

   assign mod_valid[0] = req_chan.valid;
   assign mod_rem[0]   = '0;
   assign mod_dvd[0]   = int_mag;
   assign mod_quot[0]  = '0;
   assign mod_side[0]  = {neg_x, req_chan.coord_y, req_chan.coord_x};

   for (genvar g = 0; g < IW; g++) begin : g_mod
      pvn_div_cell #(.DVW(PERIOD_W), .DW(IW), .SBW(MSIDE_W)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .enable       (advance),
         .divisor      (wrap_div),
         .in_valid     (mod_valid[g]),
         .in_rem       (mod_rem[g]),
         .in_dividend  (mod_dvd[g]),
         .in_quot      (mod_quot[g]),
         .in_side      (mod_side[g]),
         .out_valid    (mod_valid[g+1]),
         .out_rem      (mod_rem[g+1]),
         .out_dividend (mod_dvd[g+1]),
         .out_quot     (mod_quot[g+1]),
         .out_side     (mod_side[g+1])
      );
   end

   // Sign fix: a negative cell index wraps to the period minus the remainder.
   logic                      fix_valid_ff;
   logic signed [COORD_W-1:0] fix_cx_ff, fix_cy_ff;
   logic [PERIOD_W-1:0]       fix_mod_ff, fix_mod_in;
   logic                      mod_neg;

   always_comb begin
      mod_neg    = mod_side[IW][MSIDE_W-1];
      fix_mod_in = (mod_neg && mod_rem[IW] != '0) ? wrap_div - mod_rem[IW] : mod_rem[IW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_valid_ff <= 1'b0;
      end else if (advance) begin
         fix_valid_ff <= mod_valid[IW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fix_cx_ff  <= mod_side[IW][COORD_W-1:0];
         fix_cy_ff  <= mod_side[IW][2*COORD_W-1:COORD_W];
         fix_mod_ff <= fix_mod_in;
      end
   end

   // Octave units run side by side on the same point.
   logic [NOISE_W-1:0] oct_value [M];
   logic [OCT_LAT-1:0] oct_valid_ff;

   for (genvar k = 0; k < M; k++) begin : g_oct
      pvn_octave #(.OCT(k), .FRAC_BITS(FRAC_BITS)) u_octave (
         .clock        (clock),
         .enable       (advance),
         .coord_x      (fix_cx_ff),
         .coord_y      (fix_cy_ff),
         .cell_mod     (fix_mod_ff),
         .base_period  (base_period_ff),
         .noise_seed   (noise_seed_ff),
         .octave_value (oct_value[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_valid_ff <= '0;
      end else if (advance) begin
         oct_valid_ff <= {oct_valid_ff[OCT_LAT-2:0], fix_valid_ff};
      end
   end

   // Weighted octave sum, scaled so the deepest octave carries weight one.
   logic             sum_valid_ff;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_scaled;
   logic [M-1:0]     amp_div;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < M; k++) begin
         if (k < int'(octaves_used)) begin
            sum_in = sum_in + (SUM_W'(oct_value[k]) << (M - 1 - k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= oct_valid_ff[OCT_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_scaled = sum_ff >> (M - int'(octaves_used));
   assign amp_div    = M'((SUM_W'(1) << octaves_used) - SUM_W'(1));

   // Quotient chain: divide by the amplitude sum 2^n - 1.
   logic               div_valid [NOISE_W+1];
   logic [M-1:0]       div_rem   [NOISE_W+1];
   logic [NOISE_W-1:0] div_dvd   [NOISE_W+1];
   logic [NOISE_W-1:0] div_quot  [NOISE_W+1];
   logic               div_zero  [NOISE_W+1];

   assign div_valid[0] = sum_valid_ff;
   assign div_rem[0]   = sum_scaled[SUM_W-1:NOISE_W];
   assign div_dvd[0]   = sum_scaled[NOISE_W-1:0];
   assign div_quot[0]  = '0;
   assign div_zero[0]  = octaves_used == '0;

   for (genvar g = 0; g < NOISE_W; g++) begin : g_div
      pvn_div_cell #(.DVW(M), .DW(NOISE_W), .SBW(1)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .enable       (advance),
         .divisor      (amp_div),
         .in_valid     (div_valid[g]),
         .in_rem       (div_rem[g]),
         .in_dividend  (div_dvd[g]),
         .in_quot      (div_quot[g]),
         .in_side      (div_zero[g]),
         .out_valid    (div_valid[g+1]),
         .out_rem      (div_rem[g+1]),
         .out_dividend (div_dvd[g+1]),
         .out_quot     (div_quot[g+1]),
         .out_side     (div_zero[g+1])
      );
   end

   // Two-entry output queue; the head entry drives the response channel.
   logic [NOISE_W-1:0] slot0_ff, slot0_in, slot1_ff, slot1_in, push_value;
   logic               push, pop;
   logic [1:0]         write_pos;

   assign push       = advance && div_valid[NOISE_W];
   assign pop        = rsp_chan.valid && rsp_chan.ready;
   assign push_value = div_zero[NOISE_W] ? '0 : div_quot[NOISE_W];

   always_comb begin
      slot0_in      = slot0_ff;
      slot1_in      = slot1_ff;
      write_pos     = fifo_count_ff - 2'(pop);
      fifo_count_in = fifo_count_ff + 2'(push) - 2'(pop);
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (write_pos == 2'd0) begin
            slot0_in = push_value;
         end else begin
            slot1_in = push_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_count_ff <= 2'd0;
      end else begin
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_chan.valid       = fifo_count_ff != 2'd0;
   assign rsp_chan.noise_value = slot0_ff;

   // Checks on the queue and the chain.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff != 2'd3)
      else $error("output queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (fifo_count_ff == 2'd2) |-> !push)
      else $error("result pushed into a full output queue");

   a_entry_moves: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> mod_valid[1])
      else $error("accepted request did not enter the remainder chain");

   a_zero_octaves: assert property (@(posedge clock) disable iff (reset)
      (push && div_zero[NOISE_W]) |=> (fifo_count_ff != 2'd0))
      else $error("zero-octave result lost");

endmodule
